>>> hdl/i2cdiv_pkg.sv
// ----------------------------------------------------------------------------
// i2cdiv_pkg
// Shared constants and controller/datapath interface types for the bus
// clock divider search.
// ----------------------------------------------------------------------------
package i2cdiv_pkg;

  localparam int unsigned FREQ_W          = 32;
  localparam int unsigned MAX_HIGH_COUNT  = 31;
  localparam int unsigned PRE_STEPS       = 8;
  localparam int unsigned EXP_W           = $clog2(PRE_STEPS);
  localparam int unsigned HIGH_W          = $clog2(MAX_HIGH_COUNT + 1);
  // Largest divisor is 3*MAX_HIGH_COUNT + 2 + 2.
  localparam int unsigned DIVR_W          = $clog2(3 * MAX_HIGH_COUNT + 5);
  localparam int unsigned BITCNT_W        = $clog2(FREQ_W);

  localparam int unsigned PRESCALE_EXP_W  = 3;
  localparam int unsigned HIGH_COUNT_W    = 5;
  localparam int unsigned LOW_COUNT_W     = 6;
  localparam int unsigned SETHOLD_COUNT_W = 5;
  localparam int unsigned DATAVD_COUNT_W  = 4;

  localparam logic [FREQ_W-1:0] TARGET_RESET = FREQ_W'(400000);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // capture a new source frequency and reset the search
    logic load;      // set up the divider for the current candidate
    logic div_step;  // one restoring division step
    logic calc_err;  // register the absolute rate error
    logic eval;      // compare against the best candidate so far
    logic advance;   // move to the next candidate
    logic publish;   // load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic src_zero;  // incoming source frequency is zero
    logic div_last;  // final division step this cycle
    logic err_zero;  // registered error is zero
    logic last_cand; // current candidate is the final one
    logic out_free;  // result register can take a new result this cycle
  } dp_stat_t;

endpackage

>>> hdl/i2cdiv_ctrl.sv
// ----------------------------------------------------------------------------
// i2cdiv_ctrl
// Sequencer for the divider search: walks the candidates one at a time
// through the serial divider and hands the result to the output register.
// ----------------------------------------------------------------------------
module i2cdiv_ctrl import i2cdiv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_stat_t   stat_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_ERR  = 3'd3;
  localparam logic [2:0] S_EVAL = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = stat_i.src_zero ? S_DONE : S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_ERR;
        end
      end
      S_ERR: begin
        cmd_o.calc_err = 1'b1;
        state_d        = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (stat_i.err_zero || stat_i.last_cand) begin
          state_d = S_DONE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_LOAD;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_publish_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> stat_i.out_free)
    else $error("result published while the result register is occupied");

  a_stop_or_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |=> (state_q == S_LOAD) || (state_q == S_DONE))
    else $error("evaluation did not lead to the next candidate or completion");

endmodule

>>> hdl/i2cdiv_dp.sv
// ----------------------------------------------------------------------------
// i2cdiv_dp
// Datapath for the divider search: target register, candidate counters,
// bit-serial restoring divider, error compare, best-candidate registers and
// the output register.
// ----------------------------------------------------------------------------
module i2cdiv_dp import i2cdiv_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ctrl_cmd_t                  cmd_i,
  output dp_stat_t                   stat_o,
  input  logic                       cfg_write_i,
  input  logic [FREQ_W-1:0]          target_freq_hz_i,
  input  logic [FREQ_W-1:0]          src_clock_hz_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       status_o,
  output logic [PRESCALE_EXP_W-1:0]  prescale_exp_o,
  output logic [HIGH_COUNT_W-1:0]    high_count_o,
  output logic [LOW_COUNT_W-1:0]     low_count_o,
  output logic [SETHOLD_COUNT_W-1:0] sethold_count_o,
  output logic [DATAVD_COUNT_W-1:0]  datavd_count_o,
  output logic [FREQ_W-1:0]          rate_error_o
);

  // Configuration and control state.
  logic [FREQ_W-1:0]   target_q;
  logic                out_valid_q;
  logic [BITCNT_W-1:0] bitcnt_q;

  // Search payload.
  logic [FREQ_W-1:0] src_q;
  logic              src_zero_q;
  logic [EXP_W-1:0]  exp_q;
  logic [HIGH_W-1:0] high_q;
  logic [FREQ_W-1:0] dvd_q;     // dividend, shifted out as the quotient shifts in
  logic [DIVR_W-1:0] divr_q;
  logic [DIVR_W-1:0] rem_q;
  logic [FREQ_W-1:0] err_q;
  logic [EXP_W-1:0]  best_exp_q;
  logic [HIGH_W-1:0] best_high_q;
  logic [FREQ_W-1:0] best_err_q;

  // Divisor of the current candidate.
  logic [DIVR_W-1:0] extra;
  logic [DIVR_W-1:0] divr_d;

  always_comb begin
    unique case (exp_q)
      EXP_W'(0): extra = DIVR_W'(2);
      EXP_W'(1): extra = DIVR_W'(1);
      default:   extra = '0;
    endcase
    if (high_q == HIGH_W'(1)) begin
      divr_d = DIVR_W'(6) + extra;
    end else begin
      divr_d = DIVR_W'(3) * DIVR_W'(high_q) + DIVR_W'(2) + extra;
    end
  end

  // One restoring division step.
  logic [DIVR_W:0]   trial;
  logic              q_bit;
  logic [DIVR_W-1:0] rem_d;

  always_comb begin
    trial = {rem_q, dvd_q[FREQ_W-1]};
    q_bit = (trial >= {1'b0, divr_q});
    if (q_bit) begin
      rem_d = DIVR_W'(trial - {1'b0, divr_q});
    end else begin
      rem_d = trial[DIVR_W-1:0];
    end
  end

  // Absolute error of the finished quotient.
  logic [FREQ_W-1:0] err_d;
  assign err_d = (target_q > dvd_q) ? (target_q - dvd_q) : (dvd_q - target_q);

  // Derived counts of the best candidate.
  logic [FREQ_W-1:0] hi_ext;
  logic              hi_small;
  assign hi_ext   = FREQ_W'(best_high_q);
  assign hi_small = (best_high_q < HIGH_W'(2));

  assign stat_o.src_zero  = (src_clock_hz_i == '0);
  assign stat_o.div_last  = (bitcnt_q == BITCNT_W'(FREQ_W - 1));
  assign stat_o.err_zero  = (err_q == '0);
  assign stat_o.last_cand = (high_q == HIGH_W'(MAX_HIGH_COUNT)) &&
                            (exp_q == EXP_W'(PRE_STEPS - 1));
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= TARGET_RESET;
      out_valid_q <= 1'b0;
      bitcnt_q    <= '0;
    end else begin
      if (cfg_write_i) begin
        target_q <= target_freq_hz_i;
      end
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        bitcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        bitcnt_q <= bitcnt_q + BITCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      src_q       <= src_clock_hz_i;
      src_zero_q  <= (src_clock_hz_i == '0);
      exp_q       <= '0;
      high_q      <= HIGH_W'(1);
      best_exp_q  <= '0;
      best_high_q <= '0;
      best_err_q  <= '1;
    end
    if (cmd_i.load) begin
      dvd_q  <= src_q >> exp_q;
      divr_q <= divr_d;
      rem_q  <= '0;
    end
    if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[FREQ_W-2:0], q_bit};
      rem_q <= rem_d;
    end
    if (cmd_i.calc_err) begin
      err_q <= err_d;
    end
    if (cmd_i.eval && (err_q < best_err_q)) begin
      best_exp_q  <= exp_q;
      best_high_q <= high_q;
      best_err_q  <= err_q;
    end
    if (cmd_i.advance) begin
      if (high_q == HIGH_W'(MAX_HIGH_COUNT)) begin
        high_q <= HIGH_W'(1);
        exp_q  <= exp_q + EXP_W'(1);
      end else begin
        high_q <= high_q + HIGH_W'(1);
      end
    end
    if (cmd_i.publish) begin
      status_o <= src_zero_q;
      if (src_zero_q) begin
        prescale_exp_o  <= '0;
        high_count_o    <= '0;
        low_count_o     <= '0;
        sethold_count_o <= '0;
        datavd_count_o  <= '0;
        rate_error_o    <= '0;
      end else begin
        prescale_exp_o  <= PRESCALE_EXP_W'(best_exp_q);
        high_count_o    <= HIGH_COUNT_W'(hi_ext);
        low_count_o     <= hi_small ? LOW_COUNT_W'(3) : LOW_COUNT_W'(hi_ext << 1);
        sethold_count_o <= hi_small ? SETHOLD_COUNT_W'(2) : SETHOLD_COUNT_W'(hi_ext);
        datavd_count_o  <= hi_small ? DATAVD_COUNT_W'(1) : DATAVD_COUNT_W'(hi_ext >> 1);
        rate_error_o    <= best_err_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_publish_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |=> out_valid_q)
    else $error("result register not valid after publish");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> (rem_q < divr_q))
    else $error("division remainder not below divisor");

  a_zero_src_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_o) |-> (rate_error_o == '0) && (high_count_o == '0))
    else $error("no-source result carries nonzero fields");

endmodule

>>> hdl/i2c_clock_divider_search.sv
// ----------------------------------------------------------------------------
// i2c_clock_divider_search
// Finds the prescaler and clock-high count whose bus rate comes closest to
// the programmed target frequency for a given source clock.
// ----------------------------------------------------------------------------
// One transfer on the input channel carries a source clock frequency; one
// transfer on the output channel later returns the chosen prescaler exponent,
// the high, low, setup/hold and data-valid counts and the absolute rate error.
// Candidates are tried one at a time: prescalers 1 to 128 outer, high counts
// 1 to 31 inner, and each candidate's rate comes out of a bit-serial restoring
// divider that produces one quotient bit per cycle. Each candidate passes
// through a setup step, 32 division steps, an error step and a compare
// step; a full search covers 248 candidates and ends early as soon as a
// candidate hits the target exactly. A zero source frequency skips the
// candidate search and goes straight to publishing the no-source status.
// The input stalls while a search runs and while a finished search waits
// for the output register to free up; a result that merely sits in the
// output register does not hold off the next search. The target register
// resets to 400 kHz; its write port is always ready, and it should only be
// written while no search is running and no result is pending.
// ----------------------------------------------------------------------------
module i2c_clock_divider_search import i2cdiv_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Target rate register write.
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [FREQ_W-1:0]          target_freq_hz_i,
  // Source frequency input.
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [FREQ_W-1:0]          src_clock_hz_i,
  // Search result output.
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       status_o,
  output logic [PRESCALE_EXP_W-1:0]  prescale_exp_o,
  output logic [HIGH_COUNT_W-1:0]    high_count_o,
  output logic [LOW_COUNT_W-1:0]     low_count_o,
  output logic [SETHOLD_COUNT_W-1:0] sethold_count_o,
  output logic [DATAVD_COUNT_W-1:0]  datavd_count_o,
  output logic [FREQ_W-1:0]          rate_error_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // The register write is always taken in the cycle it is offered.
  assign cfg_ready_o = 1'b1;

  // The sequencer owns the input handshake and the order of the search.
  i2cdiv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds the target, the divider and the result register.
  i2cdiv_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_write_i      (cfg_valid_i && cfg_ready_o),
    .target_freq_hz_i (target_freq_hz_i),
    .src_clock_hz_i   (src_clock_hz_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .prescale_exp_o   (prescale_exp_o),
    .high_count_o     (high_count_o),
    .low_count_o      (low_count_o),
    .sethold_count_o  (sethold_count_o),
    .datavd_count_o   (datavd_count_o),
    .rate_error_o     (rate_error_o)
  );

endmodule

>>> test/tb_i2c_clock_divider_search.sv
// ----------------------------------------------------------------------------
// tb_i2c_clock_divider_search
// Self-checking testbench for the bus clock divider search.
// ----------------------------------------------------------------------------
// A queue of source frequencies feeds a valid/stall driver. A monitor on the
// rising edge predicts the chosen prescaler, counts and rate error of every
// accepted source frequency and checks each returned result, field by field
// and in order. The target rate register is rewritten between phases, once
// all outstanding results are back. The run covers the register extremes,
// a zero source, searches where no candidate beats the start value, exact
// hits deep in the search, and random traffic with stalls on both sides.
// ----------------------------------------------------------------------------
module tb_i2c_clock_divider_search;
  import i2cdiv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // With roughly 100 transfers, each of which may need a full search, plus the
  // stall burst and random gaps, a correct run stays well below CYCLE_LIMIT.
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned BURST_CYCLES = 2000;
  localparam int unsigned SETTLE_WAIT  = 100;

  // Everything one search returns, at the widths of the output ports.
  typedef struct packed {
    logic                       status;
    logic [PRESCALE_EXP_W-1:0]  pexp;
    logic [HIGH_COUNT_W-1:0]    high;
    logic [LOW_COUNT_W-1:0]     low;
    logic [SETHOLD_COUNT_W-1:0] sethold;
    logic [DATAVD_COUNT_W-1:0]  datavd;
    logic [FREQ_W-1:0]          err;
  } div_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [FREQ_W-1:0]          target_freq_hz_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [FREQ_W-1:0]          src_clock_hz_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic                       status_o;
  logic [PRESCALE_EXP_W-1:0]  prescale_exp_o;
  logic [HIGH_COUNT_W-1:0]    high_count_o;
  logic [LOW_COUNT_W-1:0]     low_count_o;
  logic [SETHOLD_COUNT_W-1:0] sethold_count_o;
  logic [DATAVD_COUNT_W-1:0]  datavd_count_o;
  logic [FREQ_W-1:0]          rate_error_o;

  // Source frequencies waiting to be offered, and predicted results waiting
  // for their transfer on the output.
  logic [FREQ_W-1:0] src_pending[$];
  div_result_t       expected_div[$];

  // Handshake flags seen at the last rising edge, read at the falling edge.
  bit          in_taken;
  bit          cfg_taken;
  logic [FREQ_W-1:0] target_now = TARGET_RESET;
  div_result_t got_div;
  div_result_t want_div;

  int unsigned idle_pct = 10;
  bit          stall_burst_req;
  int unsigned burst_left;
  bit          burst_done;

  int unsigned cycles;
  int unsigned queued;
  int unsigned accepted;
  int unsigned results;
  int unsigned exact_hits;
  int unsigned no_source;
  int unsigned mismatches;
  int unsigned target_writes;
  int unsigned p;
  int unsigned k;
  logic [FREQ_W-1:0] phase_target;

  i2c_clock_divider_search dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .target_freq_hz_i (target_freq_hz_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .src_clock_hz_i   (src_clock_hz_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .prescale_exp_o   (prescale_exp_o),
    .high_count_o     (high_count_o),
    .low_count_o      (low_count_o),
    .sethold_count_o  (sethold_count_o),
    .datavd_count_o   (datavd_count_o),
    .rate_error_o     (rate_error_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Walks every prescaler and high count in search order and keeps the first
  // candidate with a strictly smaller error, stopping at an exact hit. The
  // prescaler is 1 << e, so the division by it is a shift and 2 / prescaler
  // is 2 >> e.
  function automatic div_result_t best_divider(logic [FREQ_W-1:0] src,
                                               logic [FREQ_W-1:0] target);
    div_result_t       r;
    logic [FREQ_W-1:0] best_err;
    logic [FREQ_W-1:0] rate;
    logic [FREQ_W-1:0] err;
    logic [FREQ_W-1:0] divisor;
    int unsigned       best_exp;
    int unsigned       best_high;
    int unsigned       e;
    int unsigned       h;
    bit                hit;
    r = '0;
    if (src == '0) begin
      r.status = 1'b1;
      return r;
    end
    best_err  = '1;
    best_exp  = 0;
    best_high = 0;
    hit       = 1'b0;
    for (e = 0; e < PRE_STEPS && !hit; e++) begin
      for (h = 1; h <= MAX_HIGH_COUNT && !hit; h++) begin
        divisor = (h == 1) ? 6 + (2 >> e) : 3 * h + 2 + (2 >> e);
        rate    = (src >> e) / divisor;
        err     = (target > rate) ? target - rate : rate - target;
        if (err < best_err) begin
          best_err  = err;
          best_exp  = e;
          best_high = h;
          hit       = (err == '0);
        end
      end
    end
    // With no winning candidate the high count stays zero, which takes the
    // short-count branch below just like a high count of one.
    if (best_high < 2) begin
      r.low     = LOW_COUNT_W'(3);
      r.sethold = SETHOLD_COUNT_W'(2);
      r.datavd  = DATAVD_COUNT_W'(1);
    end else begin
      r.low     = LOW_COUNT_W'(2 * best_high);
      r.sethold = SETHOLD_COUNT_W'(best_high);
      r.datavd  = DATAVD_COUNT_W'(best_high / 2);
    end
    r.pexp = PRESCALE_EXP_W'(best_exp);
    r.high = HIGH_COUNT_W'(best_high);
    r.err  = best_err;
    return r;
  endfunction

  // A source frequency that makes candidate (e, h) land exactly on the
  // target: any value in [target*div*pre, target*div*pre + div*pre - 1].
  // When that range does not fit in 32 bits, any random frequency will do.
  function automatic logic [FREQ_W-1:0] exact_src(logic [FREQ_W-1:0] target,
                                                  int unsigned e, int unsigned h);
    longint unsigned span;
    longint unsigned lo;
    span = longint'((h == 1) ? 6 + (2 >> e) : 3 * h + 2 + (2 >> e)) << e;
    lo   = longint'(target) * span;
    if (lo + span - 1 > 64'hFFFF_FFFF) begin
      return $urandom;
    end
    return FREQ_W'(lo + $urandom_range(span - 1, 0));
  endfunction

  task automatic check_field(string fname, longint unsigned want_v,
                             longint unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", fname, want_v, got_v);
      mismatches++;
    end
  endtask

  task automatic add_src(logic [FREQ_W-1:0] v);
    src_pending.push_back(v);
    queued++;
  endtask

  // Random source frequency for the current target. Most of them are built
  // to hit some candidate exactly or just miss it, so that searches end at
  // every depth; the rest are tiny, zero or fully random values.
  task automatic add_random_src(logic [FREQ_W-1:0] target);
    int unsigned pick;
    int unsigned e;
    int unsigned h;
    pick = $urandom_range(99, 0);
    e    = $urandom_range(PRE_STEPS - 1, 0);
    h    = $urandom_range(MAX_HIGH_COUNT, 1);
    if (pick < 45) begin
      add_src(exact_src(target, e, h));
    end else if (pick < 60) begin
      add_src(exact_src(target + $urandom_range(3, 1), e, h));
    end else if (pick < 68) begin
      add_src($urandom_range(300, 0));
    end else if (pick < 72) begin
      add_src('0);
    end else begin
      add_src($urandom);
    end
  endtask

  // Returns at a falling edge once every queued frequency has been taken and
  // every predicted result has come back.
  task automatic wait_drained();
    do @(negedge clk_i); while (accepted != queued || expected_div.size() != 0);
  endtask

  // Writes the target register. Only called with the block idle.
  task automatic set_target(logic [FREQ_W-1:0] v);
    cfg_valid_i      <= 1'b1;
    target_freq_hz_i <= v;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
    target_writes++;
  endtask

  // Sender: a frequency stays on the port until its transfer happens; a new
  // one goes out unless this cycle is picked as a gap.
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (src_pending.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
        in_valid_i     <= 1'b1;
        src_clock_hz_i <= src_pending.pop_front();
      end else begin
        in_valid_i     <= 1'b0;
        src_clock_hz_i <= $urandom;
      end
    end
  end

  // Receiver: random stalls, plus one long burst on request that lets the
  // output register fill and backs the block up into its input.
  always @(negedge clk_i) begin
    if (stall_burst_req && !burst_done) begin
      burst_left  <= BURST_CYCLES;
      burst_done  <= 1'b1;
      out_stall_i <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left  <= burst_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < idle_pct);
    end
  end

  // Monitor: every transfer is seen here, on the rising edge. The target
  // copy follows register writes so each prediction uses the setting that
  // was in force when its source frequency was taken.
  always @(posedge clk_i) begin
    in_taken  = rst_ni && in_valid_i && !in_stall_o;
    cfg_taken = rst_ni && cfg_valid_i && cfg_ready_o;
    if (!rst_ni) begin
      target_now = TARGET_RESET;
    end else if (cfg_taken) begin
      target_now = target_freq_hz_i;
    end
    if (in_taken) begin
      expected_div.push_back(best_divider(src_clock_hz_i, target_now));
      accepted++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_div.size() == 0) begin
        $error("result transfer with no source frequency outstanding");
        mismatches++;
      end else begin
        want_div = expected_div.pop_front();
        got_div  = {status_o, prescale_exp_o, high_count_o, low_count_o,
                    sethold_count_o, datavd_count_o, rate_error_o};
        check_field("status", want_div.status, got_div.status);
        check_field("prescale_exp", want_div.pexp, got_div.pexp);
        check_field("high_count", want_div.high, got_div.high);
        check_field("low_count", want_div.low, got_div.low);
        check_field("sethold_count", want_div.sethold, got_div.sethold);
        check_field("datavd_count", want_div.datavd, got_div.datavd);
        check_field("rate_error", want_div.err, got_div.err);
        results++;
        if (want_div.status) begin
          no_source++;
        end else if (want_div.err == '0) begin
          exact_hits++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed, at the reset target of 400 kHz: zero source, the smallest and
    // largest sources, alternating bit patterns, common clocks, a hit on the
    // very first candidate and a hit deep in the largest prescaler.
    add_src('0);
    add_src(1);
    add_src(7);
    add_src('1);
    add_src(3_200_000);
    add_src(24_000_000);
    add_src(48_000_000);
    add_src(32'h8000_0000);
    add_src(32'h5555_5555);
    add_src(32'hAAAA_AAAA);
    add_src(exact_src(TARGET_RESET, PRE_STEPS - 1, 20));
    wait_drained();

    // Largest target: with a source too slow to give any rate above zero, no
    // candidate beats the all-ones start error.
    set_target('1);
    add_src(1);
    add_src(6);
    add_src('1);
    add_src('0);
    wait_drained();

    // Zero target: the error is the rate itself.
    set_target('0);
    add_src(100);
    add_src(5);
    add_src('1);
    wait_drained();

    // Smallest legal target.
    set_target(1);
    add_src(8);
    add_src('1);
    wait_drained();

    // Random phases. The first runs with no gaps at all; each later one picks
    // a different kind of target, up to the full 32-bit range.
    for (p = 0; p < 5; p++) begin
      case (p)
        0: phase_target = 100_000;
        1: phase_target = 1_000_000;
        2: phase_target = $urandom_range(5_000_000, 1);
        3: phase_target = $urandom;
        default: phase_target = 3_400_000;
      endcase
      idle_pct = (p == 0) ? 0 : 10;
      set_target(phase_target);
      for (k = 0; k < 14; k++) begin
        add_random_src(phase_target);
      end
      wait_drained();

      // After the second phase the receiver stops for a long burst while
      // quick first-candidate hits keep arriving, so the result register
      // fills and the input has to stall.
      if (p == 1) begin
        set_target(100_000);
        stall_burst_req = 1'b1;
        for (k = 0; k < 12; k++) begin
          add_src(exact_src(100_000, 0, 1));
        end
        wait_drained();
      end
    end

    repeat (SETTLE_WAIT) @(negedge clk_i);
    if (expected_div.size() != 0) begin
      $error("%0d results never arrived", expected_div.size());
      mismatches++;
    end

    $display("Checked %0d search results over %0d target settings.",
             results, target_writes + 1);
    $display("Of those, %0d were exact hits and %0d reported no source clock.",
             exact_hits, no_source);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
